// File: design/fhc_pkg.sv
// Shared types and constants for the half/single format converter.
// Used by the decode, shift and pack stages and by the top level.
`timescale 1ns / 1ps
`default_nettype none

package fhc_pkg;

    // Direction selector carried on tuser
    typedef enum logic {
        CMD_S2H = 1'b0,   // single to half
        CMD_H2S = 1'b1    // half to single
    } t_cmd;

    // How the fraction field of the result is formed
    typedef enum logic [1:0] {
        FRAC_ZERO  = 2'd0,   // zero, infinity
        FRAC_ONES  = 2'd1,   // NaN: all mantissa bits set
        FRAC_SHIFT = 2'd2,   // denormalize (to half) or normalize (to single)
        FRAC_COPY  = 2'd3    // plain truncation / widening
    } t_frac_sel;

    localparam int SGL_MANT_W  = 23;
    localparam int HALF_MANT_W = 10;
    localparam int SGL_EXP_W   = 8;
    localparam int HALF_EXP_W  = 5;
    localparam int SHAMT_W     = 4;
    localparam int MANT_W      = SGL_MANT_W + 1;

    localparam logic [SGL_EXP_W-1:0]  SGL_EXP_ALL    = 8'hFF;
    localparam logic [HALF_EXP_W-1:0] HALF_EXP_ALL   = 5'h1F;
    // Bias difference 127 - 15, i.e. 0x38000000 >> 23
    localparam logic [SGL_EXP_W-1:0]  BIAS_GAP       = 8'd112;
    // First single exponent that overflows a half, 0x47800000 >> 23
    localparam logic [SGL_EXP_W-1:0]  S2H_OVF_EXP    = 8'd143;
    // Last single exponent that flushes to a signed zero
    localparam logic [SGL_EXP_W-1:0]  S2H_FLUSH_EXP  = 8'd102;
    // Single exponent of a half denormal whose leading one is bit 0
    localparam logic [SGL_EXP_W-1:0]  H2S_DENORM_EXP = 8'd103;
    localparam logic [SHAMT_W-1:0]    H2S_NORM_SPAN  = 4'd10;

    // Stage 1 -> stage 2
    typedef struct packed {
        t_cmd                   cmd;
        logic                   sign;
        logic [SGL_EXP_W-1:0]   expo;      // final exponent field
        t_frac_sel              frac_sel;
        logic [SHAMT_W-1:0]     shamt;
        logic [MANT_W-1:0]      mant;      // {1, mant23} or zero-extended half mantissa
    } t_dec;

    // Stage 2 -> stage 3
    typedef struct packed {
        t_cmd                   cmd;
        logic                   sign;
        logic [SGL_EXP_W-1:0]   expo;
        logic [SGL_MANT_W-1:0]  frac;      // half fraction sits in the low bits
    } t_fld;

endpackage

`default_nettype wire

// File: design/fhc_decode.sv
// Stage 1: classifies the operand and settles exponent, fraction source and shift.
// Depends on fhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fhc_decode
    import fhc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [31:0] i_operand,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_dec             o_dec
);

    logic                   r_valid;
    t_dec                   r_dec;
    t_dec                   n_dec;
    logic [SGL_EXP_W-1:0]   v_diff;
    logic [SHAMT_W-1:0]     v_lead;
    logic [SGL_EXP_W-1:0]   s_exp;
    logic [SGL_MANT_W-1:0]  s_mant;
    logic [HALF_EXP_W-1:0]  h_exp;
    logic [HALF_MANT_W-1:0] h_mant;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_dec   = r_dec;

    assign s_exp  = i_operand[30:23];
    assign s_mant = i_operand[22:0];
    assign h_exp  = i_operand[14:10];
    assign h_mant = i_operand[9:0];
    assign v_diff = BIAS_GAP - s_exp;

    // Leading-one position of the half mantissa
    always_comb begin
        v_lead = '0;
        for (int i = 0; i < HALF_MANT_W; i++) begin
            if (h_mant[i]) begin
                v_lead = SHAMT_W'(i);
            end
        end
    end

    // Classification
    always_comb begin
        n_dec          = '0;
        n_dec.cmd      = t_cmd'(i_cmd);
        n_dec.frac_sel = FRAC_ZERO;
        if (t_cmd'(i_cmd) == CMD_S2H) begin
            n_dec.sign = i_operand[31];
            n_dec.mant = {1'b1, s_mant};
            if (s_exp >= S2H_OVF_EXP) begin
                // overflow to infinity, NaN keeps all ones
                n_dec.expo     = {3'b000, HALF_EXP_ALL};
                n_dec.frac_sel = (s_exp == SGL_EXP_ALL && s_mant != '0) ? FRAC_ONES : FRAC_ZERO;
            end else if (s_exp <= S2H_FLUSH_EXP) begin
                n_dec.frac_sel = FRAC_ZERO;
            end else if (s_exp <= BIAS_GAP) begin
                // half denormal, implicit one kept
                n_dec.frac_sel = FRAC_SHIFT;
                n_dec.shamt    = v_diff[SHAMT_W-1:0];
            end else begin
                n_dec.expo     = s_exp - BIAS_GAP;
                n_dec.frac_sel = FRAC_COPY;
            end
        end else begin
            n_dec.sign = i_operand[15];
            n_dec.mant = {{(MANT_W-HALF_MANT_W){1'b0}}, h_mant};
            if (h_exp == HALF_EXP_ALL) begin
                n_dec.expo     = SGL_EXP_ALL;
                n_dec.frac_sel = (h_mant != '0) ? FRAC_ONES : FRAC_ZERO;
            end else if (h_exp == '0) begin
                if (h_mant != '0) begin
                    // normalize: shift the leading one out past the top bit
                    n_dec.frac_sel = FRAC_SHIFT;
                    n_dec.shamt    = H2S_NORM_SPAN - v_lead;
                    n_dec.expo     = H2S_DENORM_EXP + {{(SGL_EXP_W-SHAMT_W){1'b0}}, v_lead};
                end
            end else begin
                n_dec.expo     = {{(SGL_EXP_W-HALF_EXP_W){1'b0}}, h_exp} + BIAS_GAP;
                n_dec.frac_sel = FRAC_COPY;
            end
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_dec <= n_dec;
        end
    end

    // Shift ranges the next stage relies on
    a_s2h_shamt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_dec.cmd == CMD_S2H && r_dec.frac_sel == FRAC_SHIFT
        |-> r_dec.shamt <= 4'd9)
        else $error("single-to-half denormal shift out of range");

    a_h2s_shamt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_dec.cmd == CMD_H2S && r_dec.frac_sel == FRAC_SHIFT
        |-> r_dec.shamt >= 4'd1 && r_dec.shamt <= H2S_NORM_SPAN)
        else $error("half-to-single normalize shift out of range");

endmodule

`default_nettype wire

// File: design/fhc_shift.sv
// Stage 2: forms the fraction field, with the denormalize or normalize shift.
// Depends on fhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fhc_shift
    import fhc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_dec i_dec,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_fld      o_fld
);

    logic                   r_valid;
    t_fld                   r_fld;
    t_fld                   n_fld;
    logic [HALF_MANT_W-1:0] v_right;
    logic [HALF_MANT_W-1:0] v_left;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_fld   = r_fld;

    // Right shift past the 14 dropped bits, or left shift of the half mantissa
    assign v_right = i_dec.mant[MANT_W-1 -: HALF_MANT_W] >> i_dec.shamt;
    assign v_left  = i_dec.mant[HALF_MANT_W-1:0] << i_dec.shamt;

    // Fraction select
    always_comb begin
        n_fld.cmd  = i_dec.cmd;
        n_fld.sign = i_dec.sign;
        n_fld.expo = i_dec.expo;
        n_fld.frac = '0;
        if (i_dec.cmd == CMD_S2H) begin
            case (i_dec.frac_sel)
                FRAC_ONES:  n_fld.frac = {{(SGL_MANT_W-HALF_MANT_W){1'b0}}, {HALF_MANT_W{1'b1}}};
                FRAC_SHIFT: n_fld.frac = {{(SGL_MANT_W-HALF_MANT_W){1'b0}}, v_right};
                FRAC_COPY:  n_fld.frac = {{(SGL_MANT_W-HALF_MANT_W){1'b0}},
                                          i_dec.mant[SGL_MANT_W-1 -: HALF_MANT_W]};
                default:    n_fld.frac = '0;
            endcase
        end else begin
            case (i_dec.frac_sel)
                FRAC_ONES:  n_fld.frac = {SGL_MANT_W{1'b1}};
                FRAC_SHIFT: n_fld.frac = {v_left, {(SGL_MANT_W-HALF_MANT_W){1'b0}}};
                FRAC_COPY:  n_fld.frac = {i_dec.mant[HALF_MANT_W-1:0],
                                          {(SGL_MANT_W-HALF_MANT_W){1'b0}}};
                default:    n_fld.frac = '0;
            endcase
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_fld <= n_fld;
        end
    end

endmodule

`default_nettype wire

// File: design/fhc_pack.sv
// Stage 3: packs sign, exponent and fraction into the output word; output register.
// Depends on fhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fhc_pack
    import fhc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_fld  i_fld,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [31:0] o_data
);

    logic        r_valid;
    logic        r_half;
    logic [31:0] r_data;
    logic [31:0] n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Word assembly
    always_comb begin
        if (i_fld.cmd == CMD_S2H) begin
            n_data = {16'h0000, i_fld.sign, i_fld.expo[HALF_EXP_W-1:0],
                      i_fld.frac[HALF_MANT_W-1:0]};
        end else begin
            n_data = {i_fld.sign, i_fld.expo, i_fld.frac};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
            r_half <= (i_fld.cmd == CMD_S2H);
        end
    end

    // A half result never carries bits above 15
    a_half_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_half |-> r_data[31:16] == 16'h0000)
        else $error("half result has upper bits set");

endmodule

`default_nettype wire

// File: design/float_half_format_converter.sv
// Half/single float format converter, top level: three-stage pipeline.
// Depends on fhc_pkg, fhc_decode, fhc_shift and fhc_pack.
//
// Usage:
//   Slave channel: tdata holds the operand (single bits, or half bits in
//   [15:0] with [31:16] ignored); tuser selects the direction, 0 converts
//   single to half, 1 converts half to single. A request is taken when
//   tvalid and tready are both high.
//   Master channel: tdata holds the result (half bits zero-extended, or
//   single bits). Conversion truncates; overflow gives infinity, NaN gives
//   an all-ones mantissa, tiny values give half denormals or signed zero.
// Path: an accepted request passes the decode, shift and pack registers in
//   order to tvalid on the master side; decode loads at the accepting edge.
// Throughput: one request per cycle; each stage advances whenever its
//   successor is empty or moving.
// Reset: synchronous, active low; clears every stage valid bit, so the
//   pipeline comes up empty and ready.
// Stall: while the master side holds tready low the result is held;
//   up to three requests stay in flight, then the slave tready drops.
`timescale 1ns / 1ps
`default_nettype none

module float_half_format_converter
    import fhc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] operand_bits
    input  wire logic        i_s_axis_tuser,   // [0] cmd
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata    // [31:0] converted_bits
);

    logic dec_valid;
    logic dec_ready;
    t_dec dec_bus;
    logic fld_valid;
    logic fld_ready;
    t_fld fld_bus;

    // Stage 1: classify
    fhc_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_cmd     (i_s_axis_tuser),
        .i_operand (i_s_axis_tdata),
        .o_valid   (dec_valid),
        .i_ready   (dec_ready),
        .o_dec     (dec_bus)
    );

    // Stage 2: fraction shift
    fhc_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_dec   (dec_bus),
        .o_valid (fld_valid),
        .i_ready (fld_ready),
        .o_fld   (fld_bus)
    );

    // Stage 3: pack and hold for the receiver
    fhc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fld_valid),
        .o_ready (fld_ready),
        .i_fld   (fld_bus),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

    // An empty output stage lets the whole pipeline move
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with an empty output stage");

    // An accepted request keeps the pipeline non-empty
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> dec_valid || fld_valid || o_m_axis_tvalid)
        else $error("accepted request vanished");

endmodule

`default_nettype wire

// File: tb/tb_float_half_format_converter.sv
// Testbench for float_half_format_converter: directed cases and random bursts of
// single/half conversions against a behavioral model, with random result back-pressure.
// Depends on fhc_pkg and the float_half_format_converter RTL.
`timescale 1ns / 1ps

module tb_float_half_format_converter;
    import fhc_pkg::*;

    // Exponent landmarks of the two formats (single exponent field values)
    localparam logic [7:0] SGL_EXP_MAX   = 8'hFF;
    localparam logic [7:0] HALF_TOP_EXP  = 8'd143;  // first single exponent past half range
    localparam logic [7:0] EXP_BIAS_DIFF = 8'd112;  // 127 - 15
    localparam logic [4:0] HALF_EXP_MAX  = 5'h1F;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [31:0] operand_bits
    logic        i_s_axis_tuser = 1'b0; // [0] cmd
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // [31:0] converted_bits

    // Behavioral model of the converter plus the queue of pending results
    class conversion_scoreboard;
        typedef struct {
            t_cmd        cmd;
            logic [31:0] operand;
            logic [31:0] converted;
        } t_pending;

        t_pending    pending_q[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Single to half, truncating; result zero-extended to 32 bits
        function logic [31:0] narrow_single(logic [31:0] x);
            logic [7:0]  expo;
            logic [23:0] full;
            logic [14:0] h;
            int          shamt;
            expo = x[30:23];
            if (expo >= HALF_TOP_EXP) begin
                // overflow gives infinity, NaN keeps an all-ones mantissa
                h = {HALF_EXP_MAX, (expo == SGL_EXP_MAX && x[22:0] != '0) ? 10'h3FF : 10'h000};
            end else if (expo <= EXP_BIAS_DIFF) begin
                // half denormal, implicit one kept; flush to zero past 23 bits
                shamt = 14 + int'(EXP_BIAS_DIFF) - int'(expo);
                full = {1'b1, x[22:0]};
                h = (shamt >= 24) ? 15'd0 : 15'(full >> shamt);
            end else begin
                h = {5'(expo - EXP_BIAS_DIFF), x[22:13]};
            end
            return {16'h0000, x[31], h};
        endfunction

        // Half to single; denormals normalized by leading-one position
        function logic [31:0] widen_half(logic [15:0] hf);
            logic [4:0] e;
            logic [9:0] m;
            logic [9:0] frac;
            int         top;
            e = hf[14:10];
            m = hf[9:0];
            top = 0;
            if (e == HALF_EXP_MAX) begin
                return {hf[15], SGL_EXP_MAX, (m != '0) ? 23'h7FFFFF : 23'h000000};
            end else if (e == '0) begin
                if (m == '0) begin
                    return {hf[15], 31'h0};
                end
                for (int b = 0; b < 10; b++) begin
                    if (m[b]) begin
                        top = b;
                    end
                end
                frac = 10'(m << (10 - top));
                return {hf[15], 8'(int'(EXP_BIAS_DIFF) - 9 + top), frac, 13'h0};
            end
            return {hf[15], 8'(e) + EXP_BIAS_DIFF, m, 13'h0};
        endfunction

        function void note_request(t_cmd cmd, logic [31:0] operand);
            t_pending p;
            p.cmd = cmd;
            p.operand = operand;
            p.converted = (cmd == CMD_H2S) ? widen_half(operand[15:0])
                                           : narrow_single(operand);
            pending_q.push_back(p);
        endfunction

        function void check_result(logic [31:0] got);
            t_pending p;
            if (pending_q.size() == 0) begin
                $display("%0t: result with no request pending: expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            p = pending_q.pop_front();
            if (got !== p.converted) begin
                $display("%0t: converted_bits mismatch (cmd %s, operand %h): expected %h, actual %h",
                         $time, p.cmd.name(), p.operand, p.converted, got);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    conversion_scoreboard sb = new();

    int unsigned burst_left = 0;
    int unsigned ready_mode = 0;
    int unsigned ready_phase_left = 0;

    float_half_format_converter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watch both channels at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_request(t_cmd'(i_s_axis_tuser), i_s_axis_tdata);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_result(o_m_axis_tdata);
            end
        end
    end

    // Result back-pressure: phases of always ready, light stall, heavy stall
    always @(posedge i_clk) begin
        if (ready_phase_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            ready_phase_left <= $urandom_range(16, 160);
        end else begin
            ready_phase_left <= ready_phase_left - 1;
        end
        case (ready_mode)
            0: begin
                i_m_axis_tready <= 1'b1;
            end
            1: begin
                i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // Present one request, inserting a random gap between bursts
    task automatic push_request(input t_cmd cmd, input logic [31:0] operand);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= operand;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Random request biased toward exponent boundaries and special values
    function automatic void pick_random(output t_cmd cmd, output logic [31:0] operand);
        int unsigned bias;
        bias = $urandom_range(0, 9);
        cmd = t_cmd'($urandom_range(0, 1));
        operand = $urandom;
        if (bias < 7) begin
            if (cmd == CMD_S2H) begin
                case ($urandom_range(0, 3))
                    0: operand[30:23] = 8'($urandom_range(98, 147));
                    1: operand[30:23] = 8'($urandom_range(100, 116));
                    2: operand[30:23] = ($urandom_range(0, 1) != 0) ? SGL_EXP_MAX : 8'h00;
                    default: operand[30:23] = 8'($urandom_range(139, 145));
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    operand[22:0] = '0;
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: operand[14:10] = 5'h00;
                    1: operand[14:10] = HALF_EXP_MAX;
                    default: operand[14:10] = 5'($urandom_range(1, 30));
                endcase
                // single-bit mantissas walk the normalize path
                if ($urandom_range(0, 3) == 0) begin
                    operand[9:0] = 10'(1 << $urandom_range(0, 9));
                end else if ($urandom_range(0, 7) == 0) begin
                    operand[9:0] = '0;
                end
            end
        end
    endfunction

    initial begin
        t_cmd        cmd;
        logic [31:0] operand;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single to half
        push_request(CMD_S2H, 32'h0000_0000);  // +0
        push_request(CMD_S2H, 32'h8000_0000);  // -0
        push_request(CMD_S2H, 32'h7F80_0000);  // +inf
        push_request(CMD_S2H, 32'hFF80_0000);  // -inf
        push_request(CMD_S2H, 32'h7FC0_0000);  // quiet NaN
        push_request(CMD_S2H, 32'hFF80_0001);  // negative NaN, one mantissa bit
        push_request(CMD_S2H, 32'h4780_0000);  // smallest finite overflow
        push_request(CMD_S2H, 32'hC77F_FFFF);  // largest magnitude in half range, negative
        push_request(CMD_S2H, 32'h3880_0000);  // smallest half normal
        push_request(CMD_S2H, 32'h3800_0000);  // largest denormal exponent
        push_request(CMD_S2H, 32'h3380_0000);  // last shift that keeps a bit
        push_request(CMD_S2H, 32'hB300_0000);  // underflow to -0, first flushing exponent
        push_request(CMD_S2H, 32'h0000_0001);  // single denormal
        push_request(CMD_S2H, 32'hFFFF_FFFF);
        push_request(CMD_S2H, 32'h3F80_0000);  // 1.0
        // Directed: half to single
        push_request(CMD_H2S, 32'h0000_0000);
        push_request(CMD_H2S, 32'h0000_8000);
        push_request(CMD_H2S, 32'h0000_7C00);
        push_request(CMD_H2S, 32'h0000_FC00);
        push_request(CMD_H2S, 32'h0000_7E00);
        push_request(CMD_H2S, 32'h0000_FFFF);  // negative NaN
        push_request(CMD_H2S, 32'h0000_0001);  // smallest denormal
        push_request(CMD_H2S, 32'h0000_83FF);  // largest denormal, negative
        push_request(CMD_H2S, 32'h0000_0400);
        push_request(CMD_H2S, 32'hFFFF_7BFF);  // upper half ignored

        // Random requests
        repeat (800) begin
            pick_random(cmd, operand);
            push_request(cmd, operand);
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain, then give the pipeline time to show any stray result
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
